@@ rtl/combination_rank_unrank_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the combination rank/unrank unit
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COMBINATION_RANK_UNRANK_UNIT_DEFINES_SVH
`define COMBINATION_RANK_UNRANK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CRU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cru assertion failed");
// next-cycle implication
`define CRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cru assertion failed");
`else
`define CRU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/cru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_pkg
// Widths, constants and state codes of the combination rank/unrank unit.
// ----------------------------------------------------------------------------
package cru_pkg;

   localparam int MAX_ORDER    = 8;
   localparam int MAX_ELEMENTS = 128;

   localparam int RANK_W  = 41;
   localparam int ELEM_W  = 7;
   localparam int ORDER_W = 4;
   localparam int N_W     = 8;
   localparam int JIDX_W  = 3;
   localparam int ADDR_W  = N_W + JIDX_W;
   // binomial store: rows m = 0..MAX_ELEMENTS, columns j = 1..MAX_ORDER
   localparam int MEM_DEPTH = (MAX_ELEMENTS + 1) * MAX_ORDER;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_N_ELEMENTS = '0;

   localparam logic [N_W-1:0] N_RESET = 8'd128;
   localparam logic [N_W-1:0] N_MIN   = 8'd2;
   localparam logic [N_W-1:0] N_MAX   = 8'd128;

   localparam logic KIND_RANK   = 1'b0;
   localparam logic KIND_UNRANK = 1'b1;

   typedef enum logic [11:0] {
      ST_BUILD_WR  = 12'b0000_0000_0001,
      ST_BUILD_UPD = 12'b0000_0000_0010,
      ST_IDLE      = 12'b0000_0000_0100,
      ST_START     = 12'b0000_0000_1000,
      ST_R_BASE    = 12'b0000_0001_0000,
      ST_R_SUB     = 12'b0000_0010_0000,
      ST_R_ACC     = 12'b0000_0100_0000,
      ST_U_CHK     = 12'b0000_1000_0000,
      ST_U_BASE    = 12'b0001_0000_0000,
      ST_U_LATCH   = 12'b0010_0000_0000,
      ST_U_SCAN    = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } state_type;

endpackage

@@ rtl/cru_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_req_if / cru_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface cru_req_if import cru_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [ORDER_W-1:0] order;
   logic [RANK_W-1:0]  rank_in;
   logic [ELEM_W-1:0]  elem_0;
   logic [ELEM_W-1:0]  elem_1;
   logic [ELEM_W-1:0]  elem_2;
   logic [ELEM_W-1:0]  elem_3;
   logic [ELEM_W-1:0]  elem_4;
   logic [ELEM_W-1:0]  elem_5;
   logic [ELEM_W-1:0]  elem_6;
   logic [ELEM_W-1:0]  elem_7;

   modport source (output valid, kind, order, rank_in, elem_0, elem_1, elem_2, elem_3,
                   elem_4, elem_5, elem_6, elem_7, input ready);
   modport sink   (input valid, kind, order, rank_in, elem_0, elem_1, elem_2, elem_3,
                   elem_4, elem_5, elem_6, elem_7, output ready);
endinterface

interface cru_rsp_if import cru_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank_out;
   logic [ELEM_W-1:0] res_elem_0;
   logic [ELEM_W-1:0] res_elem_1;
   logic [ELEM_W-1:0] res_elem_2;
   logic [ELEM_W-1:0] res_elem_3;
   logic [ELEM_W-1:0] res_elem_4;
   logic [ELEM_W-1:0] res_elem_5;
   logic [ELEM_W-1:0] res_elem_6;
   logic [ELEM_W-1:0] res_elem_7;
   logic              bad_input;

   modport source (output valid, rank_out, res_elem_0, res_elem_1, res_elem_2, res_elem_3,
                   res_elem_4, res_elem_5, res_elem_6, res_elem_7, bad_input, input ready);
   modport sink   (input valid, rank_out, res_elem_0, res_elem_1, res_elem_2, res_elem_3,
                   res_elem_4, res_elem_5, res_elem_6, res_elem_7, bad_input, output ready);
endinterface

@@ rtl/combination_rank_unrank_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_rank_unrank_unit
// Lexicographic rank of a strictly increasing k-subset of {0..n-1}, and back.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item: kind (0 rank, 1 unrank), order k, rank_in and
//   elem_0..elem_7. rsp_chan returns one item per request: rank_out,
//   res_elem_0..res_elem_7 and bad_input. Both are valid/ready channels.
//   The csr_ APB port holds n_elements at byte address 0 (reset 128).
// Timing:
//   After reset a build pass fills a binomial store C(m,j), m = 0..128,
//   j = 1..8, one entry per cycle and a row update step between rows,
//   with req ready low. Every table access is one read of that store.
//   Rank adds C(n-a,j) - C(n-x,j) for each element x, a being one past
//   the previous element. Unrank checks the rank against C(n,k), then
//   finds the first k-1 elements, one compared entry per cycle in the
//   downward search. A bad order or empty combination skips to DONE.
//   One item is worked at a time; a new request is taken as soon as the
//   previous result sits in the output register, even if it is stalled.
//   A stalled rsp holds its payload until the transfer completes.
// ----------------------------------------------------------------------------
`include "combination_rank_unrank_unit_defines.svh"

module combination_rank_unrank_unit import cru_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cru_req_if.sink               req_chan,
   cru_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration
   logic [N_W-1:0] n_ff, n_in;
   logic [N_W-1:0] n_eff;

   // sequencer state
   state_type          state_ff, state_in;
   logic               kind_ff, kind_in;
   logic [ORDER_W-1:0] k_ff, k_in;
   logic [ORDER_W-1:0] p_ff, p_in;
   logic [RANK_W-1:0]  idx_ff, idx_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [RANK_W-1:0]  base_ff, base_in;
   logic [N_W-1:0]     a_ff, a_in;
   logic [N_W-1:0]     m_ff, m_in;
   logic               bad_ff, bad_in;
   logic [ELEM_W-1:0]  elem_ff [MAX_ORDER];
   logic [ELEM_W-1:0]  elem_in [MAX_ORDER];
   logic [ELEM_W-1:0]  res_ff  [MAX_ORDER];
   logic [ELEM_W-1:0]  res_in  [MAX_ORDER];

   // build pass
   logic [N_W-1:0]    bm_ff, bm_in;
   logic [JIDX_W-1:0] bj_ff, bj_in;
   logic [RANK_W-1:0] row_ff [MAX_ORDER];
   logic [RANK_W-1:0] row_in [MAX_ORDER];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0] rank_out_ff, rank_out_in;
   logic [ELEM_W-1:0] res_out_ff [MAX_ORDER];
   logic [ELEM_W-1:0] res_out_in [MAX_ORDER];
   logic              bad_out_ff, bad_out_in;

   // binomial store
   logic [RANK_W-1:0] mem [MEM_DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [RANK_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] rd_addr;
   logic [RANK_W-1:0] rd_data_ff;

   // shared datapath
   logic [ORDER_W-1:0] jm1_full;
   logic [JIDX_W-1:0]  jm1;
   logic [ELEM_W-1:0]  x_cur;
   logic [N_W-1:0]     x_ext;
   logic [RANK_W-1:0]  diff;
   logic               req_xfer;
   logic               csr_wr;
   logic [N_W-1:0]     n_minus_m;
   logic [N_W-1:0]     a_next;
   logic [RANK_W-1:0]  idx_next;
   logic [ORDER_W-1:0] k_req;

   assign n_eff = (n_ff < N_MIN) ? N_MIN : ((n_ff > N_MAX) ? N_MAX : n_ff);

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[CSR_ADDR_W-1];
   assign csr_prdata = csr_paddr[CSR_ADDR_W-1] ? '0 : {{(CSR_DATA_W-N_W){1'b0}}, n_ff};
   assign n_in       = csr_wr ? csr_pwdata[N_W-1:0] : n_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign k_req          = req_chan.order;

   assign jm1_full  = k_ff - p_ff - 4'd1;
   assign jm1       = jm1_full[JIDX_W-1:0];
   assign x_cur     = elem_ff[p_ff[JIDX_W-1:0]];
   assign x_ext     = {1'b0, x_cur};
   // shared subtractor: table entry against a latched base
   assign diff      = base_ff - rd_data_ff;
   assign n_minus_m = n_eff - m_ff;
   assign a_next    = n_minus_m + 8'd1;
   assign idx_next  = idx_ff - diff;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      idx_in    = idx_ff;
      rank_in   = rank_ff;
      base_in   = base_ff;
      a_in      = a_ff;
      m_in      = m_ff;
      bad_in    = bad_ff;
      elem_in   = elem_ff;
      res_in    = res_ff;
      bm_in     = bm_ff;
      bj_in     = bj_ff;
      row_in    = row_ff;
      mem_we    = 1'b0;
      mem_waddr = {bm_ff, bj_ff};
      mem_wdata = row_ff[bj_ff];
      rd_addr   = '0;

      rsp_valid_in = (rsp_valid_ff & ~rsp_chan.ready);
      rank_out_in  = rank_out_ff;
      res_out_in   = res_out_ff;
      bad_out_in   = bad_out_ff;

      unique case (state_ff)
         ST_BUILD_WR: begin
            mem_we = 1'b1;
            bj_in  = bj_ff + 3'd1;
            if (bj_ff == 3'(MAX_ORDER - 1)) begin
               if (bm_ff == N_MAX) begin
                  state_in = ST_IDLE;
               end else begin
                  bm_in    = bm_ff + 8'd1;
                  state_in = ST_BUILD_UPD;
               end
            end
         end
         ST_BUILD_UPD: begin
            // advance the Pascal row in place: C(m,j) = C(m-1,j) + C(m-1,j-1)
            for (int j = 0; j < MAX_ORDER; j++) begin
               if (j == 0) row_in[j] = row_ff[j] + 41'd1;
               else        row_in[j] = row_ff[j] + row_ff[j-1];
            end
            state_in = ST_BUILD_WR;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in = req_chan.kind;
               k_in    = k_req;
               idx_in  = req_chan.rank_in;
               elem_in[0] = req_chan.elem_0;
               elem_in[1] = req_chan.elem_1;
               elem_in[2] = req_chan.elem_2;
               elem_in[3] = req_chan.elem_3;
               elem_in[4] = req_chan.elem_4;
               elem_in[5] = req_chan.elem_5;
               elem_in[6] = req_chan.elem_6;
               elem_in[7] = req_chan.elem_7;
               for (int i = 0; i < MAX_ORDER; i++) res_in[i] = '0;
               p_in     = '0;
               a_in     = '0;
               rank_in  = '0;
               bad_in   = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            rd_addr = {n_eff, k_ff[JIDX_W-1:0] - 3'd1};
            priority if (k_ff > 4'(MAX_ORDER) || {4'd0, k_ff} > n_eff) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else if (k_ff == '0) begin
               bad_in   = (kind_ff == KIND_UNRANK) && (idx_ff != '0);
               state_in = ST_DONE;
            end else if (kind_ff == KIND_RANK) begin
               state_in = ST_R_BASE;
            end else begin
               state_in = ST_U_CHK;
            end
         end
         ST_R_BASE: begin
            rd_addr = {n_eff - a_ff, jm1};
            if (x_ext >= n_eff || x_ext < a_ff) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_R_SUB;
            end
         end
         ST_R_SUB: begin
            base_in  = rd_data_ff;
            rd_addr  = {n_eff - x_ext, jm1};
            state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            rank_in = rank_ff + diff;
            a_in    = x_ext + 8'd1;
            p_in    = p_ff + 4'd1;
            if (p_ff + 4'd1 == k_ff) state_in = ST_DONE;
            else                     state_in = ST_R_BASE;
         end
         ST_U_CHK: begin
            // rd_data_ff holds C(n, k)
            priority if (idx_ff >= rd_data_ff) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else if (k_ff == 4'd1) begin
               res_in[0] = idx_ff[ELEM_W-1:0];
               state_in  = ST_DONE;
            end else begin
               state_in = ST_U_BASE;
            end
         end
         ST_U_BASE: begin
            rd_addr  = {n_eff - a_ff, jm1};
            state_in = ST_U_LATCH;
         end
         ST_U_LATCH: begin
            base_in  = rd_data_ff;
            m_in     = 8'd1;
            rd_addr  = {8'd1, jm1};
            state_in = ST_U_SCAN;
         end
         ST_U_SCAN: begin
            // rd_data_ff holds C(m, j); search upward in m, i.e. downward in the element n - m
            if (diff <= idx_ff) begin
               idx_in = idx_next;
               res_in[p_ff[JIDX_W-1:0]] = n_minus_m[ELEM_W-1:0];
               a_in = a_next;
               p_in = p_ff + 4'd1;
               if (p_ff + 4'd2 == k_ff) begin
                  res_in[p_ff[JIDX_W-1:0] + 3'd1] =
                     idx_next[ELEM_W-1:0] + a_next[ELEM_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_U_BASE;
               end
            end else begin
               m_in    = m_ff + 8'd1;
               rd_addr = {m_ff + 8'd1, jm1};
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               bad_out_in   = bad_ff;
               rank_out_in  = (!bad_ff && kind_ff == KIND_RANK) ? rank_ff : '0;
               for (int i = 0; i < MAX_ORDER; i++) begin
                  res_out_in[i] = (!bad_ff && kind_ff == KIND_UNRANK) ? res_ff[i] : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD_WR;
         n_ff         <= N_RESET;
         bm_ff        <= '0;
         bj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_ORDER; j++) row_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         bm_ff        <= bm_in;
         bj_ff        <= bj_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      k_ff        <= k_in;
      p_ff        <= p_in;
      idx_ff      <= idx_in;
      rank_ff     <= rank_in;
      base_ff     <= base_in;
      a_ff        <= a_in;
      m_ff        <= m_in;
      bad_ff      <= bad_in;
      elem_ff     <= elem_in;
      res_ff      <= res_in;
      rank_out_ff <= rank_out_in;
      res_out_ff  <= res_out_in;
      bad_out_ff  <= bad_out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rank_out   = rank_out_ff;
   assign rsp_chan.res_elem_0 = res_out_ff[0];
   assign rsp_chan.res_elem_1 = res_out_ff[1];
   assign rsp_chan.res_elem_2 = res_out_ff[2];
   assign rsp_chan.res_elem_3 = res_out_ff[3];
   assign rsp_chan.res_elem_4 = res_out_ff[4];
   assign rsp_chan.res_elem_5 = res_out_ff[5];
   assign rsp_chan.res_elem_6 = res_out_ff[6];
   assign rsp_chan.res_elem_7 = res_out_ff[7];
   assign rsp_chan.bad_input  = bad_out_ff;

   `CRU_ASSERT_NEXT(a_req_starts, clock, reset, req_xfer, state_ff == ST_START)
   `CRU_ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `CRU_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_U_SCAN, m_ff != '0 && m_ff <= n_eff - a_ff)
   `CRU_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_valid_ff && bad_out_ff, rank_out_ff == '0)

endmodule
